// ----- hw/rtl/hbmiad_pkg.sv -----
// Shared types, codes and helpers of the HBM interleave address decoder.
`timescale 1ns / 1ps
package hbmiad_pkg;

  localparam int unsigned NumDiesDef = 8;
  localparam int unsigned MaxStacksDef = 16;
  localparam int unsigned MaxChannelsDef = 16;
  localparam int unsigned PaddrW = 5;
  localparam int unsigned MaxPseudo = 8;

  typedef enum logic [1:0] {
    OP_DECODE = 2'd0,
    OP_RANGE  = 2'd1,
    OP_STACK  = 2'd2,
    OP_CHAN   = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOCFG     = 3'd1,
    ST_NOSTACK   = 3'd2,
    ST_CAPACITY  = 3'd3,
    ST_BADDIE    = 3'd4,
    ST_UNCOVERED = 3'd5,
    ST_NOCHAN    = 3'd6,
    ST_PROFILE   = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    MODE_LOCAL  = 2'd0,
    MODE_NUMA   = 2'd1,
    MODE_GLOBAL = 2'd2,
    MODE_RSVD   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    REG_ENABLE  = 3'd0,
    REG_MODE    = 3'd1,
    REG_SSTRIPE = 3'd2,
    REG_CSTRIPE = 3'd3,
    REG_PSTRIPE = 3'd4
  } reg_idx_e;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_SUM,
    BK_RANGE,
    BK_DIV_A,
    BK_DIV_B,
    BK_MUL,
    BK_PICK,
    BK_DIV_E,
    BK_DIV_F
  } bk_state_e;

  typedef struct packed {
    logic        enable;
    mode_e       mode;
    logic [31:0] stack_stripe;
    logic [31:0] chan_stripe;
    logic [31:0] pseudo_stripe;
  } cfg_t;

  typedef struct packed {
    opcode_e     op;
    logic [63:0] address;
    logic [2:0]  die;
    logic [63:0] length;
    logic [3:0]  stack_sel;
    logic [3:0]  channel_sel;
    logic [3:0]  pseudo_count;
    logic        entry_valid;
    logic        idx_ok;
  } fe_item_t;

  typedef struct packed {
    status_e     status;
    logic [2:0]  owner_die;
    logic [3:0]  stack_no;
    logic [3:0]  chan_no;
    logic [2:0]  pseudo_channel;
    logic [63:0] chan_offset;
  } result_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quot;
    logic [31:0] rem;
  } div_rsp_t;

  function automatic logic [6:0] popcnt(input logic [63:0] v);
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < 64; i++) begin
      n = n + 7'(v[i]);
    end
    return n;
  endfunction

endpackage

// ----- hw/rtl/hbm_interleave_address_decoder_unit.sv -----
// A table write's result is registered at the accepting edge; a decode runs through the scans,
// the shared radix-2 divider (start, 64 steps, done per division; up to six per decode) and two
// shift-add multiplies with a 32-bit multiplier.
// Throughput: one item at a time in the back end, the next taken the cycle after the result is
// popped; the front queue takes two more meanwhile. Reset: valid bits and masks clear at once.
`timescale 1ns / 1ps
module hbm_interleave_address_decoder_unit import hbmiad_pkg::*; #(
  parameter int unsigned NUM_DIES = NumDiesDef,
  parameter int unsigned MAX_STACKS = MaxStacksDef,
  parameter int unsigned MAX_CHANNELS = MaxChannelsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        opcode_i,
  input  logic [63:0]       address_i,
  input  logic [2:0]        die_i,
  input  logic [63:0]       length_i,
  input  logic [3:0]        stack_sel_i,
  input  logic [3:0]        channel_sel_i,
  input  logic [3:0]        pseudo_count_i,
  input  logic              entry_valid_i,
  output logic              empty,
  input  logic              pop,
  output logic [2:0]        status_o,
  output logic [2:0]        home_die_o,
  output logic [3:0]        stack_id_o,
  output logic [3:0]        channel_id_o,
  output logic [2:0]        pseudo_channel_o,
  output logic [63:0]       local_address_o
);

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e ridx;
  logic     item_valid, item_pop, res_valid;
  fe_item_t item;
  result_t  res;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign ridx   = reg_idx_e'(paddr[PaddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable        <= 1'b0;
      cfg_q.mode          <= MODE_NUMA;
      cfg_q.stack_stripe  <= 32'd4096;
      cfg_q.chan_stripe   <= 32'd256;
      cfg_q.pseudo_stripe <= 32'd64;
    end else if (wr_en) begin
      unique case (ridx)
        REG_ENABLE:  cfg_q.enable        <= pwdata[0];
        REG_MODE:    cfg_q.mode          <= mode_e'(pwdata[1:0]);
        REG_SSTRIPE: cfg_q.stack_stripe  <= pwdata;
        REG_CSTRIPE: cfg_q.chan_stripe   <= pwdata;
        REG_PSTRIPE: cfg_q.pseudo_stripe <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_ENABLE:  prdata = 32'(cfg_q.enable);
      REG_MODE:    prdata = 32'(cfg_q.mode);
      REG_SSTRIPE: prdata = cfg_q.stack_stripe;
      REG_CSTRIPE: prdata = cfg_q.chan_stripe;
      REG_PSTRIPE: prdata = cfg_q.pseudo_stripe;
      default:     prdata = '0;
    endcase
  end

  hbmiad_front #(
    .NUM_DIES    (NUM_DIES),
    .MAX_STACKS  (MAX_STACKS),
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .opcode_i      (opcode_i),
    .address_i     (address_i),
    .die_i         (die_i),
    .length_i      (length_i),
    .stack_sel_i   (stack_sel_i),
    .channel_sel_i (channel_sel_i),
    .pseudo_count_i(pseudo_count_i),
    .entry_valid_i (entry_valid_i),
    .item_valid_o  (item_valid),
    .item_o        (item),
    .item_pop_i    (item_pop)
  );

  hbmiad_back #(
    .NUM_DIES    (NUM_DIES),
    .MAX_STACKS  (MAX_STACKS),
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .item_valid_i(item_valid),
    .item_i      (item),
    .item_pop_o  (item_pop),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_pop_i   (pop)
  );

  assign empty            = !res_valid;
  assign status_o         = res.status;
  assign home_die_o       = res.owner_die;
  assign stack_id_o       = res.stack_no;
  assign channel_id_o     = res.chan_no;
  assign pseudo_channel_o = res.pseudo_channel;
  assign local_address_o  = res.chan_offset;

endmodule

// ----- hw/rtl/hbmiad_front.sv -----
// Front end: accepts items, checks the table-write indices and queues the items for the back end.
`timescale 1ns / 1ps
module hbmiad_front import hbmiad_pkg::*; #(
  parameter int unsigned NUM_DIES = NumDiesDef,
  parameter int unsigned MAX_STACKS = MaxStacksDef,
  parameter int unsigned MAX_CHANNELS = MaxChannelsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  opcode_i,
  input  logic [63:0] address_i,
  input  logic [2:0]  die_i,
  input  logic [63:0] length_i,
  input  logic [3:0]  stack_sel_i,
  input  logic [3:0]  channel_sel_i,
  input  logic [3:0]  pseudo_count_i,
  input  logic        entry_valid_i,
  output logic        item_valid_o,
  output fe_item_t    item_o,
  input  logic        item_pop_i
);

  fe_item_t   slot_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  fe_item_t   cls;
  logic       do_push, do_pop;

  always_comb begin
    cls.op           = opcode_e'(opcode_i);
    cls.address      = address_i;
    cls.die          = die_i;
    cls.length       = length_i;
    cls.stack_sel    = stack_sel_i;
    cls.channel_sel  = channel_sel_i;
    cls.pseudo_count = pseudo_count_i;
    cls.entry_valid  = entry_valid_i;
    unique case (opcode_e'(opcode_i))
      OP_RANGE: cls.idx_ok = int'(die_i) < NUM_DIES;
      OP_STACK: cls.idx_ok = int'(stack_sel_i) < MAX_STACKS;
      OP_CHAN:  cls.idx_ok = (int'(stack_sel_i) < MAX_STACKS) &&
                             (int'(channel_sel_i) < MAX_CHANNELS);
      default:  cls.idx_ok = 1'b1;
    endcase
  end

  assign full         = cnt_q == 2'd2;
  assign do_push      = push && !full;
  assign item_valid_o = cnt_q != 2'd0;
  assign do_pop       = item_pop_i && item_valid_o;
  assign item_o       = slot_q[rd_q];

  always_comb begin
    wr_d  = do_push ? !wr_q : wr_q;
    rd_d  = do_pop ? !rd_q : rd_q;
    cnt_d = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= cls;
    end
  end

endmodule

// ----- hw/rtl/hbmiad_div.sv -----
// Shared radix-2 restoring divider, 64-bit dividend by 32-bit divisor.
`timescale 1ns / 1ps
module hbmiad_div import hbmiad_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic        busy_q, done_q;
  logic [5:0]  cnt_q;
  logic [63:0] quo_q;
  logic [31:0] rem_q, dvs_q;
  logic [32:0] sh, diff;
  logic        ge;

  assign sh   = {rem_q, quo_q[63]};
  assign ge   = sh >= {1'b0, dvs_q};
  assign diff = sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (!busy_q && req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q && req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      // one quotient bit per cycle, msb first
      rem_q <= ge ? diff[31:0] : sh[31:0];
      quo_q <= {quo_q[62:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ----- hw/rtl/hbmiad_back.sv -----
// Back end: tables, decode sequencer around the shared divider, result register.
`timescale 1ns / 1ps
module hbmiad_back import hbmiad_pkg::*; #(
  parameter int unsigned NUM_DIES = NumDiesDef,
  parameter int unsigned MAX_STACKS = MaxStacksDef,
  parameter int unsigned MAX_CHANNELS = MaxChannelsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     item_valid_i,
  input  fe_item_t item_i,
  output logic     item_pop_o,
  output logic     res_valid_o,
  output result_t  res_o,
  input  logic     res_pop_i
);

  localparam int unsigned DW = (NUM_DIES > 1) ? $clog2(NUM_DIES) : 1;
  localparam int unsigned SW = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
  localparam int unsigned CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned NM = (MAX_STACKS > MAX_CHANNELS) ? MAX_STACKS : MAX_CHANNELS;
  localparam int unsigned XW = (NM > 1) ? $clog2(NM) : 1;

  // tables
  logic [63:0]             range_base_q [NUM_DIES];
  logic [63:0]             range_size_q [NUM_DIES];
  logic [NUM_DIES-1:0]     range_valid_q;
  logic [MAX_STACKS-1:0]   stack_valid_q;
  logic [2:0]              stack_owner_q [MAX_STACKS];
  logic [63:0]             stack_cap_q [MAX_STACKS];
  logic [3:0]              stack_pc_q [MAX_STACKS];
  logic [MAX_CHANNELS-1:0] chan_mask_q [MAX_STACKS];

  bk_state_e   state_q, state_d;
  logic [63:0] addr_q, addr_d, off_q, off_d, total_q, total_d;
  logic [63:0] idx_q, idx_d, q_q, q_d, acc_q, acc_d, mcand_q, mcand_d;
  logic [31:0] intra_q, intra_d, mplier_q, mplier_d;
  logic [2:0]  die_q, die_d, home_q, home_d;
  logic [6:0]  n_q, n_d, lane_q, lane_d, seen_q, seen_d;
  logic [NM-1:0] mask_q, mask_d;
  logic [XW-1:0] pcnt_q, pcnt_d;
  logic [SW-1:0] scnt_q, scnt_d, st_q, st_d;
  logic [DW-1:0] dcnt_q, dcnt_d;
  logic [XW-1:0] ch_q, ch_d;
  logic [3:0]  pc_q, pc_d;
  logic [4:0]  mcnt_q, mcnt_d;
  logic        phase_q, phase_d, dw_q, dw_d;
  logic        res_valid_q, res_valid_d;
  result_t     res_q, res_d;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic        cfg_bad, take, fin;
  logic [MAX_STACKS-1:0] die_mask;
  logic [6:0]  ns_all, ns_die, nc;
  logic [64:0] sum65;
  logic [63:0] cur_cap, new_total, rbase, rsize, rdiff;
  logic        scan_last, ovf, hit, range_last, bit_here, found, pc_bad;
  logic [31:0] stripe_cur;
  logic [SW-1:0] pick_st;
  logic [MAX_CHANNELS-1:0] chm;
  logic        div_st;

  hbmiad_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign cfg_bad = !cfg_i.enable || (cfg_i.mode == MODE_RSVD) || (cfg_i.stack_stripe == '0) ||
                   (cfg_i.chan_stripe == '0) || (cfg_i.pseudo_stripe == '0);
  assign take    = (state_q == BK_IDLE) && item_valid_i && !res_valid_q;
  assign item_pop_o = take;

  always_comb begin
    for (int s = 0; s < MAX_STACKS; s++) begin
      die_mask[s] = stack_valid_q[s] && (7'(stack_owner_q[s]) == 7'(dcnt_q));
    end
  end
  assign ns_all = popcnt(64'(stack_valid_q));
  assign ns_die = popcnt(64'(die_mask));

  assign cur_cap   = stack_cap_q[scnt_q];
  assign sum65     = {1'b0, total_q} + {1'b0, cur_cap};
  assign ovf       = stack_valid_q[scnt_q] && sum65[64];
  assign new_total = stack_valid_q[scnt_q] ? sum65[63:0] : total_q;
  assign scan_last = scnt_q == SW'(MAX_STACKS - 1);

  assign rbase = range_base_q[dcnt_q];
  assign rsize = range_size_q[dcnt_q];
  assign rdiff = addr_q - rbase;
  assign hit   = range_valid_q[dcnt_q] &&
                 ((cfg_i.mode != MODE_LOCAL) || (7'(dcnt_q) == 7'(die_q))) &&
                 (addr_q >= rbase) && (rdiff < rsize);
  assign range_last = dcnt_q == DW'(NUM_DIES - 1);

  assign stripe_cur = phase_q ? cfg_i.chan_stripe : cfg_i.stack_stripe;
  assign bit_here   = mask_q[pcnt_q];
  assign found      = bit_here && (seen_q == lane_q);
  assign pick_st    = SW'(pcnt_q);
  assign chm        = chan_mask_q[pick_st];
  assign nc         = popcnt(64'(chm));
  assign pc_bad     = (stack_pc_q[pick_st] == 4'd0) || (int'(stack_pc_q[pick_st]) > MaxPseudo);

  assign div_st = (state_q == BK_DIV_A) || (state_q == BK_DIV_B) ||
                  (state_q == BK_DIV_E) || (state_q == BK_DIV_F);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (take && (item_i.op == OP_DECODE) && !cfg_bad) begin
          if (cfg_i.mode == MODE_GLOBAL) begin
            if (ns_all != 7'd0) state_d = BK_SUM;
          end else if (!((cfg_i.mode == MODE_LOCAL) && (int'(item_i.die) >= NUM_DIES))) begin
            state_d = BK_RANGE;
          end
        end
      end
      BK_SUM: begin
        if (ovf) state_d = BK_IDLE;
        else if (scan_last) state_d = (addr_q >= new_total) ? BK_IDLE : BK_DIV_A;
      end
      BK_RANGE: begin
        if (hit) state_d = (ns_die == 7'd0) ? BK_IDLE : BK_DIV_A;
        else if (range_last) state_d = BK_IDLE;
      end
      BK_DIV_A: if (div_rsp.done) state_d = BK_DIV_B;
      BK_DIV_B: if (div_rsp.done) state_d = BK_MUL;
      BK_MUL:   if (mcnt_q == 5'd31) state_d = BK_PICK;
      BK_PICK: begin
        if (found) begin
          if (phase_q) state_d = BK_DIV_E;
          else if ((nc == 7'd0) || pc_bad) state_d = BK_IDLE;
          else state_d = BK_DIV_A;
        end
      end
      BK_DIV_E: if (div_rsp.done) state_d = BK_DIV_F;
      BK_DIV_F: if (div_rsp.done) state_d = BK_IDLE;
      default:  state_d = BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    addr_d = addr_q;   off_d = off_q;     total_d = total_q;  idx_d = idx_q;
    q_d = q_q;         acc_d = acc_q;     mcand_d = mcand_q;  intra_d = intra_q;
    mplier_d = mplier_q; die_d = die_q;   home_d = home_q;    n_d = n_q;
    lane_d = lane_q;   seen_d = seen_q;   mask_d = mask_q;    pcnt_d = pcnt_q;
    scnt_d = scnt_q;   dcnt_d = dcnt_q;   st_d = st_q;        ch_d = ch_q;
    pc_d = pc_q;       mcnt_d = mcnt_q;   phase_d = phase_q;
    res_d = res_q;
    fin = 1'b0;
    res_valid_d = res_valid_q && !res_pop_i;
    dw_d = div_rsp.done ? 1'b0 : (dw_q || (div_st && !dw_q));

    div_req.start    = div_st && !dw_q;
    div_req.dividend = off_q;
    div_req.divisor  = stripe_cur;
    unique case (state_q)
      BK_DIV_B: begin
        div_req.dividend = idx_q;
        div_req.divisor  = 32'(n_q);
      end
      BK_DIV_E: begin
        div_req.dividend = acc_q;
        div_req.divisor  = cfg_i.pseudo_stripe;
      end
      BK_DIV_F: begin
        div_req.dividend = q_q;
        div_req.divisor  = 32'(pc_q);
      end
      default: ;
    endcase

    unique case (state_q)
      BK_IDLE: begin
        if (take) begin
          res_d       = '0;
          res_valid_d = 1'b1;
          addr_d      = item_i.address;
          die_d       = item_i.die;
          phase_d     = 1'b0;
          scnt_d      = '0;
          dcnt_d      = '0;
          total_d     = '0;
          if (item_i.op == OP_DECODE) begin
            res_valid_d = 1'b0;
            if (cfg_bad) begin
              res_d.status = ST_NOCFG;
              res_valid_d  = 1'b1;
            end else if (cfg_i.mode == MODE_GLOBAL) begin
              mask_d = NM'(stack_valid_q);
              n_d    = ns_all;
              if (ns_all == 7'd0) begin
                res_d.status = ST_NOSTACK;
                res_valid_d  = 1'b1;
              end
            end else if ((cfg_i.mode == MODE_LOCAL) && (int'(item_i.die) >= NUM_DIES)) begin
              res_d.status = ST_BADDIE;
              res_valid_d  = 1'b1;
            end
          end
        end
      end
      BK_SUM: begin
        total_d = new_total;
        scnt_d  = scnt_q + SW'(1);
        off_d   = addr_q;
        if (ovf || (scan_last && (addr_q >= new_total))) begin
          res_d.status = ST_CAPACITY;
          fin = 1'b1;
        end
      end
      BK_RANGE: begin
        if (hit) begin
          off_d  = rdiff;
          home_d = 3'(dcnt_q);
          mask_d = NM'(die_mask);
          n_d    = ns_die;
          if (ns_die == 7'd0) begin
            res_d.status = ST_NOSTACK;
            fin = 1'b1;
          end
        end else begin
          dcnt_d = dcnt_q + DW'(1);
          if (range_last) begin
            res_d.status = ST_UNCOVERED;
            fin = 1'b1;
          end
        end
      end
      BK_DIV_A: begin
        if (div_rsp.done) begin
          idx_d   = div_rsp.quot;
          intra_d = div_rsp.rem;
        end
      end
      BK_DIV_B: begin
        if (div_rsp.done) begin
          lane_d   = 7'(div_rsp.rem);
          acc_d    = 64'(intra_q);
          mcand_d  = div_rsp.quot;
          mplier_d = stripe_cur;
          mcnt_d   = '0;
        end
      end
      BK_MUL: begin
        // shift-add: one multiplier bit per cycle
        if (mplier_q[0]) acc_d = acc_q + mcand_q;
        mcand_d  = {mcand_q[62:0], 1'b0};
        mplier_d = {1'b0, mplier_q[31:1]};
        mcnt_d   = mcnt_q + 5'd1;
        pcnt_d   = '0;
        seen_d   = '0;
      end
      BK_PICK: begin
        pcnt_d = pcnt_q + XW'(1);
        if (bit_here && !found) seen_d = seen_q + 7'd1;
        if (found) begin
          if (phase_q) begin
            ch_d = pcnt_q;
          end else begin
            st_d = pick_st;
            if (cfg_i.mode == MODE_GLOBAL) home_d = stack_owner_q[pick_st];
            off_d   = acc_q;
            n_d     = nc;
            mask_d  = NM'(chm);
            pc_d    = stack_pc_q[pick_st];
            phase_d = 1'b1;
            if (nc == 7'd0) begin
              res_d.status = ST_NOCHAN;
              fin = 1'b1;
            end else if (pc_bad) begin
              res_d.status = ST_PROFILE;
              fin = 1'b1;
            end
          end
        end
      end
      BK_DIV_E: if (div_rsp.done) q_d = div_rsp.quot;
      BK_DIV_F: begin
        if (div_rsp.done) begin
          res_d.status         = ST_OK;
          res_d.owner_die      = home_q;
          res_d.stack_no       = 4'(st_q);
          res_d.chan_no        = 4'(ch_q);
          res_d.pseudo_channel = div_rsp.rem[2:0];
          res_d.chan_offset    = acc_q;
          res_valid_d          = 1'b1;
        end
      end
      default: ;
    endcase
    if (fin) res_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= BK_IDLE;
      res_valid_q   <= 1'b0;
      dw_q          <= 1'b0;
      range_valid_q <= '0;
      stack_valid_q <= '0;
      for (int s = 0; s < MAX_STACKS; s++) chan_mask_q[s] <= '0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      dw_q        <= dw_d;
      if (take && item_i.idx_ok) begin
        unique case (item_i.op)
          OP_RANGE: range_valid_q[DW'(item_i.die)] <= item_i.entry_valid;
          OP_STACK: stack_valid_q[SW'(item_i.stack_sel)] <= item_i.entry_valid;
          OP_CHAN: begin
            chan_mask_q[SW'(item_i.stack_sel)][CW'(item_i.channel_sel)] <= item_i.entry_valid;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;   off_q <= off_d;     total_q <= total_d;  idx_q <= idx_d;
    q_q <= q_d;         acc_q <= acc_d;     mcand_q <= mcand_d;  intra_q <= intra_d;
    mplier_q <= mplier_d; die_q <= die_d;   home_q <= home_d;    n_q <= n_d;
    lane_q <= lane_d;   seen_q <= seen_d;   mask_q <= mask_d;    pcnt_q <= pcnt_d;
    scnt_q <= scnt_d;   dcnt_q <= dcnt_d;   st_q <= st_d;        ch_q <= ch_d;
    pc_q <= pc_d;       mcnt_q <= mcnt_d;   phase_q <= phase_d;  res_q <= res_d;
    if (take && item_i.idx_ok) begin
      if (item_i.op == OP_RANGE) begin
        range_base_q[DW'(item_i.die)] <= item_i.address;
        range_size_q[DW'(item_i.die)] <= item_i.length;
      end
      if ((item_i.op == OP_STACK) && item_i.entry_valid) begin
        stack_owner_q[SW'(item_i.stack_sel)] <= item_i.die;
        stack_cap_q[SW'(item_i.stack_sel)]   <= item_i.length;
        stack_pc_q[SW'(item_i.stack_sel)]    <= item_i.pseudo_count;
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ----- verif/tb_top.sv -----
// Self-checking bench for the HBM interleave address decoder: table writes, decodes, APB setup.
`timescale 1ns / 1ps
module tb_top;
  import hbmiad_pkg::*;

  typedef struct {
    opcode_e     op;
    logic [63:0] address;
    logic [2:0]  die;
    logic [63:0] length;
    logic [3:0]  stack_sel;
    logic [3:0]  channel_sel;
    logic [3:0]  pseudo_count;
    logic        entry_valid;
  } cmd_t;

  typedef struct {
    logic [2:0]  status;
    logic [2:0]  owner_die;
    logic [3:0]  stack_no;
    logic [3:0]  chan_no;
    logic [2:0]  pseudo_channel;
    logic [63:0] chan_offset;
  } loc_t;

  localparam int CycleLimit = 3000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic push = 1'b0, full, empty, pop = 1'b0;
  logic [1:0] opcode_i = '0;
  logic [63:0] address_i = '0, length_i = '0;
  logic [2:0] die_i = '0;
  logic [3:0] stack_sel_i = '0, channel_sel_i = '0, pseudo_count_i = '0;
  logic entry_valid_i = 1'b0;
  logic [2:0] status_o, home_die_o, pseudo_channel_o;
  logic [3:0] stack_id_o, channel_id_o;
  logic [63:0] local_address_o;

  hbm_interleave_address_decoder_unit dut (.*);

  always #1 clk_i = ~clk_i;

  // predictor state
  logic        cfg_en;
  logic [1:0]  cfg_mode;
  logic [31:0] cfg_sstripe, cfg_cstripe, cfg_pstripe;
  logic [63:0] rng_base [NumDiesDef];
  logic [63:0] rng_size [NumDiesDef];
  logic        rng_vld  [NumDiesDef];
  logic        stk_vld  [MaxStacksDef];
  logic [2:0]  stk_die  [MaxStacksDef];
  logic [63:0] stk_cap  [MaxStacksDef];
  logic [3:0]  stk_pc   [MaxStacksDef];
  logic [15:0] chan_mask [MaxStacksDef];

  cmd_t pending_cmds[$];
  loc_t expected_locs[$];
  int   fails = 0, cycles = 0;
  int   send_idle = 0, recv_stall = 0;
  bit   stim_done = 0;

  function automatic logic [2:0] place(input logic [63:0] off, input int stacks[$],
                                       inout loc_t r);
    int chans[$];
    logic [63:0] idx, intra, lane, in_stk, local_off;
    int st;
    idx = off / cfg_sstripe;
    intra = off % cfg_sstripe;
    lane = idx % stacks.size();
    in_stk = (idx / stacks.size()) * cfg_sstripe + intra;
    st = stacks[lane];
    for (int c = 0; c < MaxChannelsDef; c++) if (chan_mask[st][c]) chans.insert(chans.size(), c);
    if (chans.size() == 0) return ST_NOCHAN;
    idx = in_stk / cfg_cstripe;
    intra = in_stk % cfg_cstripe;
    lane = idx % chans.size();
    local_off = (idx / chans.size()) * cfg_cstripe + intra;
    if (stk_pc[st] == 0 || stk_pc[st] > MaxPseudo) return ST_PROFILE;
    r.stack_no = st[3:0];
    r.chan_no = chans[lane][3:0];
    r.pseudo_channel = 3'((local_off / cfg_pstripe) % stk_pc[st]);
    r.chan_offset = local_off;
    return ST_OK;
  endfunction

  function automatic loc_t decode_loc(input logic [63:0] addr, input logic [2:0] die);
    loc_t r;
    int stacks[$];
    logic [63:0] total;
    logic [2:0] st;
    int d;
    r = '{default: '0};
    if (!cfg_en || cfg_mode == MODE_RSVD || cfg_sstripe == 0 || cfg_cstripe == 0 ||
        cfg_pstripe == 0) begin
      r.status = ST_NOCFG;
      return r;
    end
    if (cfg_mode == MODE_GLOBAL) begin
      total = 0;
      for (int s = 0; s < MaxStacksDef; s++) if (stk_vld[s]) stacks.insert(stacks.size(), s);
      if (stacks.size() == 0) begin
        r.status = ST_NOSTACK;
        return r;
      end
      foreach (stacks[i]) begin
        if (total > ~64'd0 - stk_cap[stacks[i]]) begin
          r.status = ST_CAPACITY;
          return r;
        end
        total += stk_cap[stacks[i]];
      end
      if (addr >= total) begin
        r.status = ST_CAPACITY;
        return r;
      end
      st = place(addr, stacks, r);
      if (st == ST_OK) r.owner_die = stk_die[r.stack_no];
    end else begin
      for (d = 0; d < NumDiesDef; d++)
        if (rng_vld[d] && (cfg_mode != MODE_LOCAL || d == die) && addr >= rng_base[d] &&
            addr - rng_base[d] < rng_size[d]) break;
      if (d >= NumDiesDef) begin
        r.status = ST_UNCOVERED;
        return r;
      end
      for (int s = 0; s < MaxStacksDef; s++)
        if (stk_vld[s] && stk_die[s] == d) stacks.insert(stacks.size(), s);
      if (stacks.size() == 0) begin
        r.status = ST_NOSTACK;
        return r;
      end
      st = place(addr - rng_base[d], stacks, r);
      if (st == ST_OK) r.owner_die = d[2:0];
    end
    if (st != ST_OK) r = '{default: '0};
    r.status = st;
    return r;
  endfunction

  function automatic loc_t apply_cmd(input cmd_t c);
    loc_t r;
    r = '{default: '0};
    case (c.op)
      OP_DECODE: r = decode_loc(c.address, c.die);
      OP_RANGE: begin
        rng_base[c.die] = c.address;
        rng_size[c.die] = c.length;
        rng_vld[c.die] = c.entry_valid;
      end
      OP_STACK: begin
        stk_vld[c.stack_sel] = c.entry_valid;
        if (c.entry_valid) begin
          stk_die[c.stack_sel] = c.die;
          stk_cap[c.stack_sel] = c.length;
          stk_pc[c.stack_sel] = c.pseudo_count;
        end
      end
      default: chan_mask[c.stack_sel][c.channel_sel] = c.entry_valid;
    endcase
    return r;
  endfunction

  // driver
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (push && !full) begin
        loc_t e;
        e = apply_cmd(pending_cmds.pop_front());
        expected_locs.insert(expected_locs.size(), e);
      end
      if (pending_cmds.size() > 0 && !($urandom_range(99) < send_idle)) begin
        cmd_t c;
        c = pending_cmds[0];
        push <= 1'b1;
        opcode_i <= c.op;
        address_i <= c.address;
        die_i <= c.die;
        length_i <= c.length;
        stack_sel_i <= c.stack_sel;
        channel_sel_i <= c.channel_sel;
        pseudo_count_i <= c.pseudo_count;
        entry_valid_i <= c.entry_valid;
      end else if (push && !full) begin
        push <= 1'b0;
      end
      pop <= !($urandom_range(99) < recv_stall);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (expected_locs.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected beat: status %0d", status_o);
      end else begin
        loc_t e;
        e = expected_locs.pop_front();
        if (e.status !== status_o || e.owner_die !== home_die_o || e.stack_no !== stack_id_o ||
            e.chan_no !== channel_id_o || e.pseudo_channel !== pseudo_channel_o ||
            e.chan_offset !== local_address_o) begin
          fails++;
          if (fails <= 10)
            $display("mismatch: exp %0d/%0d/%0d/%0d/%0d/%h got %0d/%0d/%0d/%0d/%0d/%h",
                     e.status, e.owner_die, e.stack_no, e.chan_no, e.pseudo_channel,
                     e.chan_offset, status_o, home_die_o, stack_id_o, channel_id_o,
                     pseudo_channel_o, local_address_o);
        end
      end
    end
    if (cycles >= CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic apb_write(input reg_idx_e idx, input logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= PaddrW'(4 * idx);
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ENABLE:  cfg_en = val[0];
      REG_MODE:    cfg_mode = val[1:0];
      REG_SSTRIPE: cfg_sstripe = val;
      REG_CSTRIPE: cfg_cstripe = val;
      default:     cfg_pstripe = val;
    endcase
  endtask

  task automatic drain();
    while (pending_cmds.size() != 0 || expected_locs.size() != 0 || push) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
  endtask

  function automatic cmd_t mk(input opcode_e op, input logic [63:0] a, input logic [2:0] d,
                              input logic [63:0] l, input logic [3:0] s, input logic [3:0] ch,
                              input logic [3:0] pc, input logic v);
    cmd_t c;
    c.op = op; c.address = a; c.die = d; c.length = l; c.stack_sel = s;
    c.channel_sel = ch; c.pseudo_count = pc; c.entry_valid = v;
    return c;
  endfunction

  task automatic enq(input cmd_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [31:0] pick_stripe();
    case ($urandom_range(5))
      0: return 32'd1;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return 32'd1 << $urandom_range(12, 4);
    endcase
  endfunction

  // random item, weighted toward decodes that hit configured ranges
  function automatic cmd_t rnd_cmd();
    cmd_t c;
    int k;
    k = $urandom_range(99);
    c = mk(OP_DECODE, rnd64(), 3'($urandom), rnd64(), 4'($urandom), 4'($urandom),
           4'($urandom_range(9)), 1'($urandom_range(9) != 0));
    if (k < 8) c.op = OP_RANGE;
    else if (k < 16) c.op = OP_STACK;
    else if (k < 24) c.op = OP_CHAN;
    if (c.op == OP_STACK) begin
      c.length = ($urandom_range(3) == 0) ? rnd64() : 64'($urandom_range(1 << 20));
      if ($urandom_range(5) == 0) c.pseudo_count = 4'($urandom);
    end
    if (c.op == OP_RANGE) begin
      c.address = ($urandom_range(3) == 0) ? rnd64() : 64'(c.die) << 32;
      c.length = ($urandom_range(3) == 0) ? rnd64() : 64'd1 << 28;
    end
    if (c.op == OP_DECODE && k < 90) begin
      c.address = (cfg_mode == MODE_GLOBAL) ? 64'($urandom_range(1 << 21)) :
                  ((64'(3'($urandom)) << 32) | 64'($urandom_range(1 << 28)));
    end
    return c;
  endfunction

  task automatic fill_tables();
    for (int d = 0; d < NumDiesDef; d++)
      enq(mk(OP_RANGE, 64'(d) << 32, 3'(d), 64'd1 << 28, 0, 0, 0, 1));
    for (int s = 0; s < MaxStacksDef; s++) begin
      enq(mk(OP_STACK, 0, 3'(s / 2), 64'($urandom_range(1 << 20)),
             4'(s), 0, 4'($urandom_range(8, 1)), 1));
      for (int ch = 0; ch < 4; ch++)
        enq(mk(OP_CHAN, 0, 0, 0, 4'(s), 4'($urandom), 0, 1));
    end
  endtask

  initial begin
    cfg_en = 0; cfg_mode = MODE_NUMA; cfg_sstripe = 4096; cfg_cstripe = 256; cfg_pstripe = 64;
    for (int i = 0; i < NumDiesDef; i++) begin
      rng_base[i] = 0; rng_size[i] = 0; rng_vld[i] = 0;
    end
    for (int i = 0; i < MaxStacksDef; i++) begin
      stk_vld[i] = 0; stk_die[i] = 0; stk_cap[i] = 0; stk_pc[i] = 0; chan_mask[i] = 0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: disabled, empty tables, then edge cases
    enq(mk(OP_DECODE, 64'h1000, 0, 0, 0, 0, 0, 0));
    drain();
    apb_write(REG_ENABLE, 32'd1);
    enq(mk(OP_DECODE, 64'h1000, 0, 0, 0, 0, 0, 0));
    enq(mk(OP_RANGE, 64'd0, 3'd7, ~64'd0, 0, 0, 0, 1));
    enq(mk(OP_DECODE, 64'h1000, 3'd7, 0, 0, 0, 0, 0));
    enq(mk(OP_STACK, ~64'd0, 3'd7, 64'd4096, 4'hF, 0, 4'd0, 1));
    enq(mk(OP_DECODE, 64'h20, 3'd7, 0, 0, 0, 0, 0));
    enq(mk(OP_CHAN, 0, 0, 0, 4'hF, 4'hF, 0, 1));
    enq(mk(OP_DECODE, 64'h20, 3'd7, 0, 0, 0, 0, 0));
    enq(mk(OP_STACK, 0, 3'd7, 64'd4096, 4'hF, 0, 4'hF, 1));
    enq(mk(OP_DECODE, 64'h20, 3'd7, 0, 0, 0, 0, 0));
    enq(mk(OP_STACK, 0, 3'd7, ~64'd0, 4'hF, 0, 4'd8, 1));
    enq(mk(OP_DECODE, ~64'd0, 3'd7, 0, 0, 0, 0, 0));
    enq(mk(OP_STACK, 0, 3'd0, 0, 4'hF, 0, 4'd1, 0));
    enq(mk(OP_DECODE, 64'h20, 3'd7, 0, 0, 0, 0, 0));
    enq(mk(OP_CHAN, 0, 0, 0, 4'hF, 4'hF, 0, 0));
    drain();
    apb_write(REG_MODE, MODE_LOCAL);
    enq(mk(OP_DECODE, 64'h20, 3'd0, 0, 0, 0, 0, 0));
    drain();
    apb_write(REG_MODE, MODE_GLOBAL);
    enq(mk(OP_STACK, 0, 3'd1, ~64'd0, 4'd0, 0, 4'd2, 1));
    enq(mk(OP_STACK, 0, 3'd2, ~64'd0, 4'd1, 0, 4'd2, 1));
    enq(mk(OP_DECODE, 64'h20, 3'd0, 0, 0, 0, 0, 0));
    enq(mk(OP_STACK, 0, 3'd2, 0, 4'd1, 0, 4'd2, 0));
    enq(mk(OP_DECODE, ~64'd0, 3'd0, 0, 0, 0, 0, 0));
    drain();
    apb_write(REG_MODE, MODE_RSVD);
    enq(mk(OP_DECODE, 64'h20, 3'd0, 0, 0, 0, 0, 0));
    drain();
    apb_write(REG_SSTRIPE, 32'd0);
    apb_write(REG_MODE, MODE_NUMA);
    enq(mk(OP_DECODE, 64'h20, 3'd0, 0, 0, 0, 0, 0));
    drain();
    apb_write(REG_SSTRIPE, 32'd4096);
    apb_write(REG_CSTRIPE, 32'd0);
    enq(mk(OP_DECODE, 64'h20, 3'd0, 0, 0, 0, 0, 0));
    drain();
    apb_write(REG_CSTRIPE, 32'd256);
    apb_write(REG_PSTRIPE, 32'd0);
    enq(mk(OP_DECODE, 64'h20, 3'd0, 0, 0, 0, 0, 0));
    drain();
    apb_write(REG_PSTRIPE, 32'd64);
    fill_tables();
    drain();

    // random phases across idling profiles and register settings
    for (int ph = 0; ph < 11; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 78; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 78; end
        default: begin send_idle = 35; recv_stall = 35; end
      endcase
      apb_write(REG_ENABLE, 32'(ph != 5));
      apb_write(REG_MODE, 32'(ph % 3));
      apb_write(REG_SSTRIPE, pick_stripe());
      apb_write(REG_CSTRIPE, pick_stripe());
      apb_write(REG_PSTRIPE, pick_stripe());
      if (ph == 6) fill_tables();
      for (int i = 0; i < 32; i++) enq(rnd_cmd());
      drain();
    end
    stim_done = 1;
    if (fails == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule

// ----- files.f -----
hw/rtl/hbmiad_pkg.sv
hw/rtl/hbmiad_front.sv
hw/rtl/hbmiad_div.sv
hw/rtl/hbmiad_back.sv
hw/rtl/hbm_interleave_address_decoder_unit.sv
verif/tb_top.sv
